// ----- hw/rtl/ipfd_pkg.sv -----
// Shared types, status codes and the fixed non-public range table for the
// IPv4 prefix filter. No dependencies.
package ipfd_pkg;

    // Result status codes
    localparam logic [2:0] ST_STORED    = 3'd0;
    localparam logic [2:0] ST_DUP       = 3'd1;
    localparam logic [2:0] ST_BADLEN    = 3'd2;
    localparam logic [2:0] ST_HOSTBITS  = 3'd3;
    localparam logic [2:0] ST_NONPUBLIC = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;
    localparam logic [2:0] ST_CLEARED   = 3'd6;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_PUBLIC_ONLY = 2'd0;
    localparam logic [1:0] CFG_REPUTATION  = 2'd1;
    localparam logic [1:0] CFG_CATEGORY    = 2'd2;
    localparam logic [1:0] CFG_SOURCE      = 2'd3;

    localparam int RSV_COUNT = 15;

    localparam logic [31:0] RSV_NET [RSV_COUNT] = '{
        32'h0000_0000, 32'h0a00_0000, 32'h6440_0000, 32'h7f00_0000,
        32'ha9fe_0000, 32'hac10_0000, 32'hc000_0000, 32'hc000_0200,
        32'hc058_6300, 32'hc0a8_0000, 32'hc612_0000, 32'hc633_6400,
        32'hcb00_7100, 32'he000_0000, 32'hf000_0000
    };

    localparam logic [5:0] RSV_LEN [RSV_COUNT] = '{
        6'd8, 6'd8, 6'd10, 6'd8, 6'd16, 6'd12, 6'd24, 6'd24,
        6'd24, 6'd16, 6'd15, 6'd24, 6'd24, 6'd4, 6'd4
    };

    // Key as stored: prefix length in 37..32, address in 31..0
    typedef logic [37:0] key_t;

    typedef struct packed {
        logic       reject;
        logic [2:0] code;
    } chk_res_t;

    typedef struct packed {
        logic start;
        logic clear;
        key_t key;
    } tbl_req_t;

    typedef struct packed {
        logic       done;
        logic       dup;
        logic       full;
        logic [7:0] slot;
    } tbl_res_t;

    // Network mask; all ones for lengths of 32 and above
    function automatic logic [31:0] net_mask(input logic [5:0] len);
        net_mask = ~(32'hffff_ffff >> len);
    endfunction

endpackage

// ----- hw/rtl/ipv4_prefix_filter_dedup_unit.sv -----
// Top level of the IPv4 prefix filter with duplicate suppression.
// Depends on ipfd_pkg, ipfd_prefix_check and ipfd_key_table.
//
// Usage
//  - Input beats (s_*) carry an operation, an IPv4 address and a prefix
//    length; every input beat yields exactly one result beat on m_*.
//  - An insert is checked for length, host bits and (with the public-only
//    register set) overlap with the fixed non-public ranges, then scanned
//    against the stored keys. A new key is appended and returned with the
//    configured score, category and source; other outcomes carry only the
//    status, all other fields zero.
//  - A clear beat empties the table and returns the cleared status.
//  - Configuration goes through cfg_we / cfg_index / cfg_wdata, one write
//    per cycle; the user must write only with no beat in flight (unchecked).
// Timing
//  - One beat at a time. A rejected or clear beat goes from the check state
//    straight to the result state; an insert that reaches the table waits
//    in the search state while the stored keys are read from the key memory
//    once per cycle, until a match or the end of the fill count.
//  - The result sits in an output register, so the next beat is accepted
//    while the previous result is still stalled by m_ready low.
// Reset
//  - aresetn (synchronous, low) empties the table by zeroing the fill
//    count; no clearing pass over the memory. Config returns to defaults.
module ipv4_prefix_filter_dedup_unit #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [31:0] s_address_value,
    input  logic [5:0]  s_prefix_length,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status_code,
    output logic [7:0]  m_slot_index,
    output logic [5:0]  m_key_length,
    output logic [31:0] m_entry_address,
    output logic [31:0] m_entry_score,
    output logic [7:0]  m_entry_category,
    output logic [31:0] m_entry_source
);
    import ipfd_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CHECK  = 2'd1;
    localparam logic [1:0] S_SEARCH = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0]  state_reg, state_next;

    // config registers
    logic        req_pub_reg;
    logic [31:0] score_reg;
    logic [7:0]  cat_reg;
    logic [31:0] source_reg;

    // captured beat
    logic        op_reg;
    logic [31:0] addr_reg;
    logic [5:0]  len_reg;

    // pending result
    logic [2:0]  res_code_reg, res_code_next;
    logic [7:0]  res_slot_reg, res_slot_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [2:0]  m_code_reg;
    logic [7:0]  m_slot_reg;
    logic [5:0]  m_klen_reg;
    logic [31:0] m_addr_reg;
    logic [31:0] m_score_reg;
    logic [7:0]  m_cat_reg;
    logic [31:0] m_source_reg;

    chk_res_t    chk;
    tbl_req_t    tbl_req;
    tbl_res_t    tbl_res;
    logic        in_fire;
    logic        out_load;
    logic        stored;

    ipfd_prefix_check u_check (
        .addr        (addr_reg),
        .len         (len_reg),
        .public_only (req_pub_reg),
        .result      (chk)
    );

    ipfd_key_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (tbl_req),
        .res     (tbl_res)
    );

    assign s_ready  = state_reg == S_IDLE;
    assign in_fire  = s_valid && s_ready;
    assign out_load = (state_reg == S_RESULT) && (!m_valid_reg || m_ready);
    assign stored   = res_code_reg == ST_STORED;

    // table is driven only from the check state
    always_comb begin
        tbl_req.start = (state_reg == S_CHECK) && (op_reg == OP_INSERT) && !chk.reject;
        tbl_req.clear = (state_reg == S_CHECK) && (op_reg == OP_CLEAR);
        tbl_req.key   = {len_reg, addr_reg};
    end

    always_comb begin
        state_next    = state_reg;
        res_code_next = res_code_reg;
        res_slot_next = res_slot_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                res_slot_next = 8'd0;
                if (op_reg == OP_CLEAR) begin
                    res_code_next = ST_CLEARED;
                    state_next    = S_RESULT;
                end else if (chk.reject) begin
                    res_code_next = chk.code;
                    state_next    = S_RESULT;
                end else begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (tbl_res.done) begin
                    state_next = S_RESULT;
                    if (tbl_res.dup) begin
                        res_code_next = ST_DUP;
                    end else if (tbl_res.full) begin
                        res_code_next = ST_FULL;
                    end else begin
                        res_code_next = ST_STORED;
                        res_slot_next = tbl_res.slot;
                    end
                end
            end
            S_RESULT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            req_pub_reg <= 1'b1;
            score_reg   <= '0;
            cat_reg     <= '0;
            source_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_PUBLIC_ONLY: req_pub_reg <= cfg_wdata[0];
                    CFG_REPUTATION:  score_reg   <= cfg_wdata;
                    CFG_CATEGORY:    cat_reg     <= cfg_wdata[7:0];
                    CFG_SOURCE:      source_reg  <= cfg_wdata;
                    default:         ;
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        res_code_reg <= res_code_next;
        res_slot_reg <= res_slot_next;
        if (in_fire) begin
            op_reg   <= s_operation;
            addr_reg <= s_address_value;
            len_reg  <= s_prefix_length;
        end
        if (out_load) begin
            // only a stored entry carries payload
            m_code_reg   <= res_code_reg;
            m_slot_reg   <= stored ? res_slot_reg : 8'd0;
            m_klen_reg   <= stored ? len_reg + 6'd8 : 6'd0;
            m_addr_reg   <= stored ? addr_reg : 32'd0;
            m_score_reg  <= stored ? score_reg : 32'd0;
            m_cat_reg    <= stored ? cat_reg : 8'd0;
            m_source_reg <= stored ? source_reg : 32'd0;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status_code    = m_code_reg;
    assign m_slot_index     = m_slot_reg;
    assign m_key_length     = m_klen_reg;
    assign m_entry_address  = m_addr_reg;
    assign m_entry_score    = m_score_reg;
    assign m_entry_category = m_cat_reg;
    assign m_entry_source   = m_source_reg;

    a_accept_to_check: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> state_reg == S_CHECK)
        else $error("accepted beat did not enter check");

    a_table_done_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_res.done |-> state_reg == S_SEARCH)
        else $error("table finished outside search");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_status_code))
        else $error("result beat dropped or changed while stalled");

endmodule

// ----- hw/rtl/ipfd_prefix_check.sv -----
// Prefix validity and non-public overlap classifier.
// Depends on ipfd_pkg.
module ipfd_prefix_check (
    input  logic [31:0]       addr,
    input  logic [5:0]        len,
    input  logic              public_only,
    output ipfd_pkg::chk_res_t result
);
    import ipfd_pkg::*;

    logic [RSV_COUNT-1:0] overlap;
    logic                 bad_len;
    logic                 host_bits;

    // Two prefixes overlap when they agree over the shorter length
    always_comb begin
        for (int i = 0; i < RSV_COUNT; i++) begin
            overlap[i] = ((addr ^ RSV_NET[i]) &
                          net_mask((len < RSV_LEN[i]) ? len : RSV_LEN[i])) == 32'd0;
        end
    end

    assign bad_len   = len > 6'd32;
    assign host_bits = (addr & ~net_mask(len)) != 32'd0;

    always_comb begin
        result.reject = 1'b1;
        if (bad_len) begin
            result.code = ST_BADLEN;
        end else if (host_bits) begin
            result.code = ST_HOSTBITS;
        end else if (public_only && (|overlap)) begin
            result.code = ST_NONPUBLIC;
        end else begin
            result.reject = 1'b0;
            result.code   = ST_STORED;
        end
    end

endmodule

// ----- hw/rtl/ipfd_key_table.sv -----
// Key memory with fill count, linear duplicate scan and append on miss.
// Depends on ipfd_pkg.
module ipfd_key_table #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ipfd_pkg::tbl_req_t req,
    output ipfd_pkg::tbl_res_t res
);
    import ipfd_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    key_t          key_mem [TABLE_DEPTH];
    key_t          rd_data_reg;
    key_t          key_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic          pend_reg, pend_next;
    logic          busy_reg, busy_next;

    logic          issue;
    logic          hit;
    logic          scan_end;
    logic          full;
    logic          mem_we;

    assign issue    = busy_reg && (ptr_reg < cnt_reg);
    assign hit      = busy_reg && pend_reg && (rd_data_reg == key_reg);
    assign scan_end = busy_reg && !issue && !pend_reg;
    assign full     = cnt_reg == CW'(TABLE_DEPTH);
    assign mem_we   = scan_end && !full;

    // Fill count replaces any clearing of the store
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[cnt_reg[IW-1:0]] <= key_reg;
        end
        rd_data_reg <= key_mem[ptr_reg[IW-1:0]];
    end

    always_comb begin
        cnt_next  = cnt_reg;
        ptr_next  = ptr_reg;
        pend_next = issue;
        busy_next = busy_reg;
        if (req.clear) begin
            cnt_next = '0;
        end
        if (req.start) begin
            ptr_next  = '0;
            pend_next = 1'b0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (issue) begin
                ptr_next = ptr_reg + CW'(1);
            end
            if (hit || scan_end) begin
                busy_next = 1'b0;
                pend_next = 1'b0;
            end
            if (mem_we) begin
                cnt_next = cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            ptr_reg  <= '0;
            pend_reg <= 1'b0;
            busy_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            ptr_reg  <= ptr_next;
            pend_reg <= pend_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            key_reg <= req.key;
        end
    end

    assign res.done = hit || scan_end;
    assign res.dup  = hit;
    assign res.full = !hit && full;
    assign res.slot = 8'(cnt_reg);

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_dup_no_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (hit && !req.clear) |=> cnt_reg == $past(cnt_reg))
        else $error("duplicate hit changed fill count");

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !req.start && !req.clear)
        else $error("table request while scan in progress");

endmodule
